// ----- rtl/ndsc_pkg.sv -----
// Shared types and constants of the nested delimiter scanner.
`timescale 1ns / 1ps
`default_nettype none

package ndsc_pkg;

  localparam int CH_W         = 8;
  localparam int OFFSET_W     = 17;
  localparam int TERM_LEN_W   = 4;
  localparam int TERM_BYTES_W = 64;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_LEN   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_BYTES = 4'd1;

  // Characters with a meaning to the scanner.
  localparam logic [CH_W-1:0] CH_LBRACE  = 8'h7B;
  localparam logic [CH_W-1:0] CH_RBRACE  = 8'h7D;
  localparam logic [CH_W-1:0] CH_LSQUARE = 8'h5B;
  localparam logic [CH_W-1:0] CH_RSQUARE = 8'h5D;
  localparam logic [CH_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [CH_W-1:0] CH_DQUOTE  = 8'h22;
  localparam logic [CH_W-1:0] CH_SQUOTE  = 8'h27;
  localparam logic [CH_W-1:0] CH_BSLASH  = 8'h5C;

  typedef enum logic [1:0] {
    CL_BRACE  = 2'd0,
    CL_SQUARE = 2'd1,
    CL_PAREN  = 2'd2
  } closer_e;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_DOUBLE = 2'd1,
    Q_SINGLE = 2'd2
  } quote_e;

  // Control word of the closer stack.
  typedef struct packed {
    logic    clear;
    logic    push;
    logic    pop;
    closer_e code;
  } stk_ctrl_t;

  // Control word shared by all cells of the byte window.
  typedef struct packed {
    logic clear;
    logic shift;
  } win_ctrl_t;

  // One result beat.
  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
    logic                overflow;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/ndsc_if.sv -----
// Handshake channel interfaces of the nested delimiter scanner.
`timescale 1ns / 1ps
`default_nettype none

interface ndsc_in_if;
  logic                      valid;
  logic                      ready;
  logic [ndsc_pkg::CH_W-1:0] ch;
  logic                      is_last;

  modport source (output valid, output ch, output is_last, input ready);
  modport sink   (input valid, input ch, input is_last, output ready);
endinterface

interface ndsc_res_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [ndsc_pkg::OFFSET_W-1:0] offset;
  logic                          overflow;

  modport source (output valid, output found, output offset, output overflow, input ready);
  modport sink   (input valid, input found, input offset, input overflow, output ready);
endinterface

interface ndsc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ndsc_pkg::CFG_IDX_W-1:0]  index;
  logic [ndsc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ndsc_win_cell.sv -----
// One cell of the recent-byte window: a byte, its eligibility mark and a compare.
`timescale 1ns / 1ps
`default_nettype none

module ndsc_win_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ndsc_pkg::win_ctrl_t       ctrl_i,
  input  logic [ndsc_pkg::CH_W-1:0] byte_i,
  input  logic                      elig_i,
  input  logic [ndsc_pkg::CH_W-1:0] want_i,
  input  logic                      active_i,
  output logic [ndsc_pkg::CH_W-1:0] byte_o,
  output logic                      elig_o,
  output logic                      match_o
);

  logic [ndsc_pkg::CH_W-1:0] byte_q;
  logic                      elig_q;

  // The compare looks at the byte that moves into this cell in this cycle.
  assign match_o = !active_i || (byte_i == want_i);
  assign byte_o  = byte_q;
  assign elig_o  = elig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elig_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      elig_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      elig_q <= elig_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ndsc_closer_stack.sv -----
// Stack of expected closing brackets: top in a register, the rest in a memory.
`timescale 1ns / 1ps
`default_nettype none

module ndsc_closer_stack #(
  parameter int STACK_DEPTH = 16,
  localparam int CNT_W = $clog2(STACK_DEPTH + 1),
  localparam int MEM_D = (STACK_DEPTH > 1) ? STACK_DEPTH - 1 : 1,
  localparam int AW    = (MEM_D > 1) ? $clog2(MEM_D) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ndsc_pkg::stk_ctrl_t ctrl_i,
  output logic [CNT_W-1:0]    count_o,
  output logic                full_o,
  output ndsc_pkg::closer_e   top_o
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

  ndsc_pkg::closer_e mem_q [MEM_D];
  ndsc_pkg::closer_e top_q;
  ndsc_pkg::closer_e rd_q;
  ndsc_pkg::closer_e byp_data_q;
  ndsc_pkg::closer_e second;
  logic              byp_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_d;
  logic [CNT_W-1:0]  rd_idx;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              do_push;

  assign full_o  = (count_q == DEPTH_C);
  assign do_push = ctrl_i.push && !full_o;
  assign count_o = count_q;
  assign top_o   = top_q;

  // Entry just below the top: a push hands the old top over directly, since the
  // memory is written with it at the very address that is read.
  assign second = byp_q ? byp_data_q : rd_q;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (do_push) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  assign rd_idx  = (count_d >= CNT_W'(2)) ? count_d - CNT_W'(2) : '0;
  assign rd_addr = AW'(rd_idx);
  assign wr_addr = AW'(count_q - CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      byp_q   <= do_push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push && (count_q != '0)) begin
      mem_q[wr_addr] <= top_q;
    end
    rd_q       <= mem_q[rd_addr];
    byp_data_q <= top_q;
    if (do_push) begin
      top_q <= ctrl_i.code;
    end else if (ctrl_i.pop) begin
      top_q <= second;
    end
  end

  a_full_push_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push && full_o && !ctrl_i.clear |=> count_q == $past(count_q))
    else $error("push onto a full stack changed its count");

  a_push_sets_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !ctrl_i.clear |=> top_q == $past(ctrl_i.code) && count_q != '0)
    else $error("pushed closer is not on top");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> count_q != '0 && !ctrl_i.push)
    else $error("pop from an empty stack or together with a push");

endmodule

`default_nettype wire

// ----- rtl/nested_delimiter_scanner_core.sv -----
// Top level of the nested delimiter scanner: lexer state, window cells, stack, result queue.
//
//   channel  dir  beat payload            accepted when
//   cfg_i    in   index, data             cfg_i.valid && cfg_i.ready (always ready)
//   in_i     in   ch, is_last             in_i.valid && in_i.ready
//   res_o    out  found, offset, overflow res_o.valid && res_o.ready
//
// One text byte is taken in every cycle while the queue has room; its result, if any,
// is in the result queue after the following clock edge. The per-byte loop is the lexer,
// the stack top and the window compare, all of which settle in the cycle of the byte.
// The result queue holds two beats; input stalls only while both are waiting.
// Reset leaves the terminator at one zero byte and the scan state empty; the stack
// memory needs no clearing pass, as only entries written during the text are read.
`timescale 1ns / 1ps
`default_nettype none

module nested_delimiter_scanner_core #(
  parameter int STACK_DEPTH = 16,
  parameter int MAX_TERM    = 8,
  parameter int MAX_LEN     = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ndsc_cfg_if.sink          cfg_i,
  ndsc_in_if.sink           in_i,
  ndsc_res_if.source        res_o
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int CW    = $clog2(MAX_LEN + 1);
  localparam int XW    = CW + ndsc_pkg::OFFSET_W;
  localparam int TW    = (MAX_TERM > 1) ? $clog2(MAX_TERM) : 1;
  localparam int LW    = ndsc_pkg::TERM_LEN_W;
  localparam logic [CW-1:0] MAX_LEN_C  = CW'(MAX_LEN);
  localparam logic [LW-1:0] MAX_TERM_C = LW'(MAX_TERM);

  // Configuration registers.
  logic [LW-1:0]                     term_len_q;
  logic [ndsc_pkg::TERM_BYTES_W-1:0] term_bytes_q;

  // Scan state.
  ndsc_pkg::quote_e quote_q, quote_d;
  logic             esc_q, esc_d;
  logic [CW-1:0]    byte_cnt_q, byte_cnt_d;
  logic             match_done_q, match_done_d;
  logic             ovf_q, ovf_d;

  logic             acc;
  logic             live;
  logic             last;
  logic [ndsc_pkg::CH_W-1:0] ch;
  logic             plain;
  logic             is_opener;
  logic             elig;
  logic             hit;
  logic             ovf_now;
  logic             res_push;
  logic [LW-1:0]    len_eff;
  logic [LW-1:0]    back;
  logic [TW-1:0]    tap;

  // Stack side.
  ndsc_pkg::stk_ctrl_t stk_ctrl;
  ndsc_pkg::closer_e   stk_top;
  ndsc_pkg::closer_e   open_code;
  ndsc_pkg::closer_e   close_code;
  logic                close_valid;
  logic [CNT_W-1:0]    stk_count;
  logic                stk_full;

  // Window chain.
  ndsc_pkg::win_ctrl_t       win_ctrl;
  logic [ndsc_pkg::CH_W-1:0] win_byte_in  [MAX_TERM];
  logic [ndsc_pkg::CH_W-1:0] win_byte_out [MAX_TERM];
  logic [MAX_TERM-1:0]       win_elig_in;
  logic [MAX_TERM-1:0]       win_elig_out;
  logic [MAX_TERM-1:0]       win_match;

  // Result queue.
  ndsc_pkg::res_t res_new;
  ndsc_pkg::res_t head_q, tail_q;
  logic [1:0]     res_cnt_q;
  logic           res_pop;

  logic [CW-1:0]  off_full;
  logic [CW-1:0]  len_full;
  logic [XW-1:0]  off_x;
  logic [XW-1:0]  len_x;

  // ---------------------------------------------------------------------------
  // Config: always ready; user must send writes only while the block is idle (unchecked).
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_len_q   <= LW'(1);
      term_bytes_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ndsc_pkg::CFG_TERM_LEN:   term_len_q   <= cfg_i.data[LW-1:0];
        ndsc_pkg::CFG_TERM_BYTES: term_bytes_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // A length beyond the window acts as the full window.
  assign len_eff = (term_len_q > MAX_TERM_C) ? MAX_TERM_C : term_len_q;
  assign back    = (len_eff == '0) ? '0 : len_eff - LW'(1);
  assign tap     = TW'(back);

  // ---------------------------------------------------------------------------
  // Input side and lexer. Once a match is reported the rest of the text is
  // swallowed; only its last byte still clears the state.
  // ---------------------------------------------------------------------------
  assign in_i.ready = (res_cnt_q != 2'd2);
  assign acc        = in_i.valid && in_i.ready;
  assign ch         = in_i.ch;
  assign last       = in_i.is_last;
  assign live       = acc && !match_done_q;

  // A byte seen outside strings and escapes.
  assign plain = !esc_q && (quote_q == ndsc_pkg::Q_NONE);

  assign is_opener = (ch == ndsc_pkg::CH_LBRACE) || (ch == ndsc_pkg::CH_LSQUARE) ||
                     (ch == ndsc_pkg::CH_LPAREN);

  assign elig = plain && (stk_count == '0) && !is_opener &&
                (ch != ndsc_pkg::CH_DQUOTE) && (ch != ndsc_pkg::CH_SQUOTE) &&
                (ch != ndsc_pkg::CH_BSLASH);

  always_comb begin
    open_code = ndsc_pkg::CL_PAREN;
    if (ch == ndsc_pkg::CH_LBRACE) begin
      open_code = ndsc_pkg::CL_BRACE;
    end else if (ch == ndsc_pkg::CH_LSQUARE) begin
      open_code = ndsc_pkg::CL_SQUARE;
    end
  end

  always_comb begin
    close_valid = 1'b1;
    close_code  = ndsc_pkg::CL_PAREN;
    if (ch == ndsc_pkg::CH_RBRACE) begin
      close_code = ndsc_pkg::CL_BRACE;
    end else if (ch == ndsc_pkg::CH_RSQUARE) begin
      close_code = ndsc_pkg::CL_SQUARE;
    end else if (ch != ndsc_pkg::CH_RPAREN) begin
      close_valid = 1'b0;
    end
  end

  always_comb begin
    quote_d = quote_q;
    esc_d   = esc_q;
    if (esc_q) begin
      esc_d = 1'b0;
    end else if (quote_q == ndsc_pkg::Q_DOUBLE) begin
      if (ch == ndsc_pkg::CH_DQUOTE) begin
        quote_d = ndsc_pkg::Q_NONE;
      end else if (ch == ndsc_pkg::CH_BSLASH) begin
        esc_d = 1'b1;
      end
    end else if (quote_q == ndsc_pkg::Q_SINGLE) begin
      if (ch == ndsc_pkg::CH_SQUOTE) begin
        quote_d = ndsc_pkg::Q_NONE;
      end else if (ch == ndsc_pkg::CH_BSLASH) begin
        esc_d = 1'b1;
      end
    end else if (ch == ndsc_pkg::CH_DQUOTE) begin
      quote_d = ndsc_pkg::Q_DOUBLE;
    end else if (ch == ndsc_pkg::CH_SQUOTE) begin
      quote_d = ndsc_pkg::Q_SINGLE;
    end else if (ch == ndsc_pkg::CH_BSLASH) begin
      esc_d = 1'b1;
    end
  end

  // Stack requests. A closer that does not match the top is simply ignored.
  assign stk_ctrl.clear = acc && last;
  assign stk_ctrl.push  = live && plain && is_opener;
  assign stk_ctrl.pop   = live && plain && (stk_count != '0) && close_valid &&
                          (close_code == stk_top);
  assign stk_ctrl.code  = open_code;

  ndsc_closer_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (stk_ctrl),
    .count_o (stk_count),
    .full_o  (stk_full),
    .top_o   (stk_top)
  );

  // The overflow of this very byte already counts for its own result.
  assign ovf_now = ovf_q || (stk_ctrl.push && stk_full);

  // ---------------------------------------------------------------------------
  // Window chain. Cell 0 takes the new byte, every other cell the content of
  // its neighbour; cell k compares against terminator byte len-1-k.
  // ---------------------------------------------------------------------------
  assign win_ctrl.clear = acc && last;
  assign win_ctrl.shift = live;

  for (genvar k = 0; k < MAX_TERM; k++) begin : g_cell
    localparam logic [LW-1:0] K_C = LW'(k);
    logic          active;
    logic [LW-1:0] j;
    logic [2:0]    jsel;
    logic [ndsc_pkg::CH_W-1:0] want;

    assign active = (K_C < len_eff);
    assign j      = len_eff - LW'(1) - K_C;
    assign jsel   = j[2:0];
    assign want   = term_bytes_q[{jsel, 3'b000} +: ndsc_pkg::CH_W];

    if (k == 0) begin : g_head
      assign win_byte_in[k] = ch;
      assign win_elig_in[k] = elig;
    end else begin : g_link
      assign win_byte_in[k] = win_byte_out[k-1];
      assign win_elig_in[k] = win_elig_out[k-1];
    end

    ndsc_win_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (win_ctrl),
      .byte_i   (win_byte_in[k]),
      .elig_i   (win_elig_in[k]),
      .want_i   (want),
      .active_i (active),
      .byte_o   (win_byte_out[k]),
      .elig_o   (win_elig_out[k]),
      .match_o  (win_match[k])
    );
  end

  // The oldest byte of the candidate must have been eligible; with an empty
  // terminator that is the new byte itself.
  assign hit = live && win_elig_in[tap] && (&win_match);

  // ---------------------------------------------------------------------------
  // Offsets. The reported start saturates at the length limit.
  // ---------------------------------------------------------------------------
  assign off_full = ((byte_cnt_q >= MAX_LEN_C) || (CW'(back) > byte_cnt_q)) ?
                    MAX_LEN_C : byte_cnt_q - CW'(back);
  assign len_full = (byte_cnt_q >= MAX_LEN_C) ? MAX_LEN_C : byte_cnt_q + CW'(1);
  assign off_x    = XW'(off_full);
  assign len_x    = XW'(len_full);

  assign res_new.found    = hit;
  assign res_new.offset   = hit ? off_x[ndsc_pkg::OFFSET_W-1:0]
                                : len_x[ndsc_pkg::OFFSET_W-1:0];
  assign res_new.overflow = ovf_now;
  assign res_push         = hit || (live && last);

  always_comb begin
    match_done_d = match_done_q;
    ovf_d        = ovf_q;
    byte_cnt_d   = byte_cnt_q;
    if (acc && last) begin
      match_done_d = 1'b0;
      ovf_d        = 1'b0;
      byte_cnt_d   = '0;
    end else if (live) begin
      match_done_d = hit;
      ovf_d        = ovf_now;
      if (byte_cnt_q < MAX_LEN_C) begin
        byte_cnt_d = byte_cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q      <= ndsc_pkg::Q_NONE;
      esc_q        <= 1'b0;
      match_done_q <= 1'b0;
      ovf_q        <= 1'b0;
      byte_cnt_q   <= '0;
    end else begin
      match_done_q <= match_done_d;
      ovf_q        <= ovf_d;
      byte_cnt_q   <= byte_cnt_d;
      if (acc && last) begin
        quote_q <= ndsc_pkg::Q_NONE;
        esc_q   <= 1'b0;
      end else if (live) begin
        quote_q <= quote_d;
        esc_q   <= esc_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Two-beat result queue; the head drives the output channel.
  // ---------------------------------------------------------------------------
  assign res_pop        = res_o.valid && res_o.ready;
  assign res_o.valid    = (res_cnt_q != 2'd0);
  assign res_o.found    = head_q.found;
  assign res_o.offset   = head_q.offset;
  assign res_o.overflow = head_q.overflow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= 2'd0;
    end else if (res_push && !res_pop) begin
      res_cnt_q <= res_cnt_q + 2'd1;
    end else if (res_pop && !res_push) begin
      res_cnt_q <= res_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_pop) begin
      if (res_push && (res_cnt_q == 2'd1)) begin
        head_q <= res_new;
      end else begin
        head_q <= tail_q;
        if (res_push) begin
          tail_q <= res_new;
        end
      end
    end else if (res_push) begin
      if (res_cnt_q == 2'd0) begin
        head_q <= res_new;
      end else begin
        tail_q <= res_new;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checks on the scan state.
  // ---------------------------------------------------------------------------
  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last |=> byte_cnt_q == '0 && !match_done_q && stk_count == '0 && !ovf_q)
    else $error("scan state not cleared after the last byte");

  a_escape_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    live && esc_q && !last |=> !esc_q)
    else $error("escape outlived the byte it covers");

  a_hit_latches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit && !last |=> match_done_q && res_cnt_q != 2'd0)
    else $error("match not recorded or its result lost");

endmodule

`default_nettype wire

// ----- bench/ndsc_scan_check.sv -----
// Scoreboard for the nested delimiter scanner: predicts every result beat and compares it.
`timescale 1ns / 1ps
`default_nettype none

module ndsc_scan_check
  import ndsc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ndsc_cfg_if  cfg_mon,
  ndsc_in_if   byte_mon,
  ndsc_res_if  res_mon,
  output int   mismatch_total_o,
  output int   results_owed_o
);

  localparam int STACK_DEPTH = 16;
  localparam int MAX_TERM    = 8;
  localparam int MAX_LEN     = 65536;

  // Shadow copy of the registers and of the scan state.
  logic [TERM_LEN_W-1:0]   term_len_q   = 4'd1;
  logic [TERM_BYTES_W-1:0] term_bytes_q = '0;
  closer_e                 closers [STACK_DEPTH];
  int                      depth;
  quote_e                  quote;
  logic                    escaped;
  logic [CH_W-1:0]         recent [MAX_TERM];
  logic                    recent_ok [MAX_TERM];
  int                      next_pos;
  logic                    matched;
  logic                    nest_overflow;

  res_t awaited_results [$];
  int   mismatches = 0;
  int   owed       = 0;

  assign mismatch_total_o = mismatches;
  assign results_owed_o   = owed;

  task automatic report_mismatch(input string what);
    $display("%0t ns scan check: %s", $time, what);
    mismatches++;
  endtask

  task automatic clear_text();
    depth         = 0;
    quote         = Q_NONE;
    escaped       = 1'b0;
    next_pos      = 0;
    matched       = 1'b0;
    nest_overflow = 1'b0;
    for (int k = 0; k < MAX_TERM; k++) begin
      recent[k]    = '0;
      recent_ok[k] = 1'b0;
    end
  endtask

  task automatic open_bracket(input closer_e code);
    if (depth < STACK_DEPTH) begin
      closers[depth] = code;
      depth++;
    end else begin
      nest_overflow = 1'b1;
    end
  endtask

  // Advances the shadow scan by one text byte and queues the result it causes.
  task automatic scan_byte(input logic [CH_W-1:0] c, input logic last);
    int   pos;
    int   len;
    int   back;
    int   off;
    logic ok;
    logic hit;
    res_t r;
    pos = next_pos;
    len = (term_len_q > MAX_TERM) ? MAX_TERM : int'(term_len_q);
    if (matched) begin
      // The rest of a matched text is swallowed until its last byte.
      if (last) clear_text();
    end else begin
      ok = !escaped && quote == Q_NONE && depth == 0 &&
           !(c inside {CH_DQUOTE, CH_SQUOTE, CH_LBRACE, CH_LSQUARE, CH_LPAREN, CH_BSLASH});
      if (escaped) begin
        escaped = 1'b0;
      end else if (quote != Q_NONE) begin
        if (c == ((quote == Q_DOUBLE) ? CH_DQUOTE : CH_SQUOTE)) quote = Q_NONE;
        else if (c == CH_BSLASH) escaped = 1'b1;
      end else if (c == CH_DQUOTE) begin
        quote = Q_DOUBLE;
      end else if (c == CH_SQUOTE) begin
        quote = Q_SINGLE;
      end else if (c == CH_LBRACE) begin
        open_bracket(CL_BRACE);
      end else if (c == CH_LSQUARE) begin
        open_bracket(CL_SQUARE);
      end else if (c == CH_LPAREN) begin
        open_bracket(CL_PAREN);
      end else if (c == CH_BSLASH) begin
        escaped = 1'b1;
      end else if (depth > 0) begin
        // Only the closer that matches the top of the stack pops it.
        if ((c == CH_RBRACE  && closers[depth-1] == CL_BRACE)  ||
            (c == CH_RSQUARE && closers[depth-1] == CL_SQUARE) ||
            (c == CH_RPAREN  && closers[depth-1] == CL_PAREN)) depth--;
      end

      for (int k = MAX_TERM - 1; k > 0; k--) begin
        recent[k]    = recent[k-1];
        recent_ok[k] = recent_ok[k-1];
      end
      recent[0]    = c;
      recent_ok[0] = ok;

      if (len == 0) begin
        hit = ok;
      end else begin
        hit = recent_ok[len-1];
        for (int k = 0; k < len; k++) begin
          if (recent[k] != term_bytes_q[8*(len-1-k) +: 8]) hit = 1'b0;
        end
      end

      if (hit) begin
        back       = (len == 0) ? 0 : len - 1;
        off        = (pos >= MAX_LEN || back > pos) ? MAX_LEN : pos - back;
        r.found    = 1'b1;
        r.offset   = off[OFFSET_W-1:0];
        r.overflow = nest_overflow;
        awaited_results.insert(awaited_results.size(), r);
        matched    = 1'b1;
      end else if (last) begin
        off        = (pos >= MAX_LEN) ? MAX_LEN : pos + 1;
        r.found    = 1'b0;
        r.offset   = off[OFFSET_W-1:0];
        r.overflow = nest_overflow;
        awaited_results.insert(awaited_results.size(), r);
      end

      if (last) clear_text();
      else if (next_pos < MAX_LEN) next_pos++;
    end
  endtask

  task automatic compare_result();
    res_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result beat found=%0b offset=%0d overflow=%0b",
                                res_mon.found, res_mon.offset, res_mon.overflow));
    end else begin
      want = awaited_results.pop_front();
      if (res_mon.found !== want.found)
        report_mismatch($sformatf("found is %0b, predicted %0b", res_mon.found, want.found));
      if (res_mon.offset !== want.offset)
        report_mismatch($sformatf("offset is %0d, predicted %0d", res_mon.offset, want.offset));
      if (res_mon.overflow !== want.overflow)
        report_mismatch($sformatf("overflow is %0b, predicted %0b",
                                  res_mon.overflow, want.overflow));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_len_q   = 4'd1;
      term_bytes_q = '0;
      clear_text();
      awaited_results.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) compare_result();
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_TERM_LEN:   term_len_q   = cfg_mon.data[TERM_LEN_W-1:0];
          CFG_TERM_BYTES: term_bytes_q = cfg_mon.data;
          default: ;
        endcase
      end
      if (byte_mon.valid && byte_mon.ready) scan_byte(byte_mon.ch, byte_mon.is_last);
    end
    owed = awaited_results.size();
  end

endmodule

`default_nettype wire

// ----- bench/nested_delimiter_scanner_core_test.sv -----
// Top of the nested delimiter scanner bench: clock, reset, text stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none

module nested_delimiter_scanner_core_test;
  import ndsc_pkg::*;

  // Cycles in a row with no beat on any channel before the run is abandoned.
  localparam int QUIET_LIMIT = 2000;
  // Extra cycles granted after the last expected beat: a result is registered into the
  // output queue when its byte is taken, so these cover anything still in flight.
  localparam int SETTLE_CYCLES = 4;

  // Byte pools for building texts. Plain filler deliberately shares a few characters
  // with the terminator pool, so that stray matches turn up in the middle of a text.
  localparam logic [7:0][7:0] FILLER     = "ab x1=;,";
  localparam logic [7:0][7:0] TERM_CHARS = "END=>;,\n";
  localparam logic [2:0][7:0] OPENERS    = {CH_LPAREN, CH_LSQUARE, CH_LBRACE};
  localparam logic [2:0][7:0] CLOSERS    = {CH_RPAREN, CH_RSQUARE, CH_RBRACE};
  localparam logic [8:0][7:0] SPECIALS   = {CH_DQUOTE, CH_SQUOTE, CH_LBRACE, CH_LSQUARE,
                                            CH_LPAREN, CH_RBRACE, CH_RSQUARE, CH_RPAREN,
                                            CH_BSLASH};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  ndsc_cfg_if cfg_ch ();
  ndsc_in_if  byte_ch ();
  ndsc_res_if res_ch ();

  nested_delimiter_scanner_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (byte_ch),
    .res_o  (res_ch)
  );

  int mismatch_total;
  int results_owed;

  ndsc_scan_check scoreboard (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_mon          (cfg_ch),
    .byte_mon         (byte_ch),
    .res_mon          (res_ch),
    .mismatch_total_o (mismatch_total),
    .results_owed_o   (results_owed)
  );

  // Idling rates of the two sides, in percent of cycles.
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int bytes_sent    = 0;
  int quiet_cycles  = 0;

  // The terminator currently programmed, so that texts can be built around it.
  logic [TERM_LEN_W-1:0]   term_len_now   = 4'd1;
  logic [TERM_BYTES_W-1:0] term_bytes_now = '0;

  logic [CH_W-1:0] text_q [$];

  // The receiver decides afresh at every falling edge whether to take a result beat.
  always @(negedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog: a correct run never goes long without some beat changing hands.
  always @(posedge clk_i) begin
    if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("nested_delimiter_scanner_core_test: FAIL");
      $finish;
    end
  end

  // Offers one text byte, with random idle cycles in front of it, and returns at the
  // falling edge after it was taken. Valid is left high, so that the next byte can
  // follow straight on; whoever stops sending lowers it.
  task automatic send_byte(input logic [CH_W-1:0] c, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.ch      <= c;
    byte_ch.is_last <= last;
    do @(posedge clk_i); while (!byte_ch.ready);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // Stops the byte stream and waits until every predicted result beat has arrived,
  // then a little longer for bytes that cause no result. The block is idle afterwards.
  task automatic settle();
    byte_ch.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes both registers back to back; only ever called once the block has settled.
  task automatic write_terminator(input logic [TERM_LEN_W-1:0] len,
                                  input logic [TERM_BYTES_W-1:0] bytes);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_TERM_LEN;
    cfg_ch.data  <= CFG_DATA_W'(len);
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.index <= CFG_TERM_BYTES;
    cfg_ch.data  <= bytes;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid   <= 1'b0;
    term_len_now   = len;
    term_bytes_now = bytes;
  endtask

  // Picks a new terminator. Short ones dominate so that matches are frequent; the
  // length is sometimes zero, sometimes the full eight and sometimes oversized.
  task automatic pick_terminator();
    logic [TERM_LEN_W-1:0]   len;
    logic [TERM_BYTES_W-1:0] bytes;
    case ($urandom_range(9))
      0:       len = 4'd0;
      1, 2, 3: len = 4'd1;
      4, 5:    len = 4'd2;
      6:       len = 4'd3;
      7:       len = 4'd8;
      8:       len = TERM_LEN_W'($urandom_range(4, 7));
      default: len = TERM_LEN_W'($urandom_range(9, 15));
    endcase
    for (int j = 0; j < 8; j++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: bytes[8*j +: 8] = TERM_CHARS[$urandom_range(7)];
        6, 7:             bytes[8*j +: 8] = FILLER[$urandom_range(7)];
        8:                bytes[8*j +: 8] = SPECIALS[$urandom_range(8)];
        default:          bytes[8*j +: 8] = CH_W'($urandom_range(255));
      endcase
    end
    settle();
    write_terminator(len, bytes);
  endtask

  // Appends one byte to the text being built.
  task automatic add_byte(input logic [CH_W-1:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  task automatic put_filler(input int n);
    for (int i = 0; i < n; i++) add_byte(FILLER[$urandom_range(7)]);
  endtask

  // Appends the terminator, now and then cut short so that only a prefix is present.
  task automatic put_terminator();
    int n;
    n = (term_len_now > 8) ? 8 : int'(term_len_now);
    if (n > 1 && $urandom_range(3) == 0) n = $urandom_range(1, n - 1);
    for (int j = 0; j < n; j++) add_byte(term_bytes_now[8*j +: 8]);
  endtask

  // Builds one text. Most texts are made of pieces, not always well-formed - bracket groups,
  // quoted strings, escapes and deep nesting - with terminators scattered inside and
  // outside them; the rest is raw noise over the whole byte range.
  task automatic make_text(input logic noisy);
    int   o;
    int   pieces;
    logic [CH_W-1:0] q;
    int   opened [$];
    text_q.delete();
    if (noisy) begin
      repeat ($urandom_range(1, 24)) add_byte(CH_W'($urandom_range(255)));
    end else begin
      pieces = $urandom_range(1, 6);
      repeat (pieces) begin
        case ($urandom_range(9))
          0, 1: put_filler($urandom_range(1, 4));
          2, 3: put_terminator();
          4: begin
            // A bracket group, left open now and then.
            o = $urandom_range(2);
            add_byte(OPENERS[o]);
            put_filler($urandom_range(0, 3));
            if ($urandom_range(1) == 1) put_terminator();
            if ($urandom_range(4) != 0) add_byte(CLOSERS[o]);
          end
          5: begin
            // A quoted string, possibly with an escaped quote or the other quote inside.
            q = ($urandom_range(1) == 1) ? CH_DQUOTE : CH_SQUOTE;
            add_byte(q);
            put_filler($urandom_range(0, 2));
            if ($urandom_range(1) == 1) put_terminator();
            case ($urandom_range(2))
              0:       begin add_byte(CH_BSLASH); add_byte(q); end
              1:       add_byte((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
              default: ;
            endcase
            if ($urandom_range(4) != 0) add_byte(q);
          end
          6: begin
            add_byte(CH_BSLASH);
            if ($urandom_range(1) == 1) put_terminator();
            else add_byte(CH_W'($urandom_range(255)));
          end
          7: add_byte(CLOSERS[$urandom_range(2)]);
          8: begin
            // Nesting around the stack depth, so that pushes are sometimes dropped.
            opened.delete();
            repeat ($urandom_range(12, 20)) begin
              o = $urandom_range(2);
              opened.insert(opened.size(), o);
              add_byte(OPENERS[o]);
              if ($urandom_range(3) == 0) put_filler(1);
            end
            if ($urandom_range(3) != 0) begin
              while (opened.size() != 0) begin
                add_byte(CLOSERS[opened[opened.size() - 1]]);
                opened.delete(opened.size() - 1);
              end
            end
            put_filler($urandom_range(0, 2));
            if ($urandom_range(1) == 1) put_terminator();
          end
          default: add_byte(SPECIALS[$urandom_range(8)]);
        endcase
      end
      if (text_q.size() == 0) put_filler(1);
    end
  endtask

  // One idling setting: texts until the byte budget is spent, with the terminator
  // changed between texts every so often, always with the block drained first.
  task automatic run_phase(input int src_pct, input int sink_pct, input int budget);
    int start;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    start         = bytes_sent;
    while (bytes_sent - start < budget) begin
      if ($urandom_range(5) == 0) pick_terminator();
      make_text($urandom_range(9) < 2);
      send_text();
    end
  endtask

  initial begin
    byte_ch.valid   = 1'b0;
    byte_ch.ch      = '0;
    byte_ch.is_last = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_TERM_LEN;
    cfg_ch.data     = '0;
    res_ch.ready    = 1'b0;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_pct  = 23;
    sink_idle_pct = 71;

    // After reset the terminator is a single zero byte.
    text_q = '{"a", 8'h00};
    send_text();

    // Empty terminator: the first byte outside the brackets matches.
    settle();
    write_terminator(4'd0, '0);
    text_q = '{CH_LPAREN, "a", CH_RPAREN, "b"};
    send_text();

    // Two-byte terminator hidden in a string and behind an escape, then matching on
    // the very last byte of the text.
    settle();
    write_terminator(4'd2, {48'd0, ">", "="});
    text_q = '{CH_DQUOTE, "=", ">", CH_DQUOTE, CH_BSLASH, "=", ">", "=", ">"};
    send_text();

    // Oversized length acts as eight; the text ends part-way through the terminator.
    settle();
    write_terminator(4'd15, "HGFEDCBA");
    text_q = '{"A", "B", "C"};
    send_text();

    // Widest terminator with every bit set.
    settle();
    write_terminator(4'd8, '1);
    text_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_text();

    run_phase(23, 71, 475);
    run_phase(71, 23, 475);
    run_phase(0, 0, 475);

    settle();
    repeat (8) @(negedge clk_i);
    if (mismatch_total == 0 && results_owed == 0) begin
      $display("nested_delimiter_scanner_core_test: PASS");
    end else begin
      $display("nested_delimiter_scanner_core_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
